/* design/audio_looper_echo_mix_unit_macros.svh */
// ----------------------------------------------------------------------------
// Audio looper echo mix unit: assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef AUDIO_LOOPER_ECHO_MIX_UNIT_MACROS_SVH
`define AUDIO_LOOPER_ECHO_MIX_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ALEM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alem: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define ALEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alem: next-cycle check failed");

`endif

/* design/alem_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Audio looper echo mix package
// Fixed constants of the sample format and the Q0.15 mixer.
// ----------------------------------------------------------------------------
package alem_pkg;

    // Offset-binary midpoint of the converter.
    localparam logic [15:0] MID_CODE    = 16'h7FFF;
    // Unity weight in Q0.15.
    localparam logic [16:0] UNITY_GAIN  = 17'd32768;
    // Echo weight after reset, about 0.4.
    localparam logic [15:0] GAIN_RESET  = 16'd13107;
    // Midpoint scaled to Q0.15 plus half an LSB for rounding.
    localparam logic signed [34:0] MIX_OFFSET = 35'sd1073725440;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [33:0] product_t;
    typedef logic signed [34:0] mix_acc_t;

endpackage
`default_nettype wire

/* design/alem_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports; read data is registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
module alem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

/* design/audio_looper_echo_mix_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Audio looper echo mix unit
// Records offset-binary samples into a ring memory and plays them back mixed
// with a delayed echo tap.
// ----------------------------------------------------------------------------
// Usage:
// Each input word is one sample tick (record_held, adc_sample) on the
// in_valid/in_stall channel. A tick with record_held high stores the sample
// and returns nothing. A tick with record_held low returns one dac_value word
// on the out_valid/out_stall channel, through the three pipeline registers.
// One word is accepted every cycle while in_stall is low; record and
// playback ticks may alternate freely. The sample memory is read through
// two ports in the accept cycle and written through one, so the rate is set
// by that single memory access. When the receiver stalls, the three pipeline
// registers keep filling and in_stall rises only once all three hold a word.
// The user writes mix_gain through mix_gain_we/mix_gain_wdata while idle only;
// the block does not enforce it. Reset restores the start positions and clears
// a fill count; the memory is not swept. Entries at or beyond the fill count
// read as silence, so the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module audio_looper_echo_mix_unit #(
    parameter int DEPTH      = 524288,
    parameter int ECHO_START = 4000
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        record_held,
    input  wire logic [15:0] adc_sample,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [15:0] dac_value,
    input  wire logic        mix_gain_we,
    input  wire logic [15:0] mix_gain_wdata
);

    `include "audio_looper_echo_mix_unit_macros.svh"

    import alem_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] ECHO_RESET = AW'(ECHO_START % DEPTH);
    localparam logic [AW:0]   DEPTH_A    = (AW+1)'(DEPTH);
    localparam logic [FW-1:0] DEPTH_F    = FW'(DEPTH);

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                              input logic [AW-1:0] lend);
        logic [AW:0] nxt;
        nxt = {1'b0, pos} + (AW+1)'(1);
        if (nxt >= {1'b0, lend} || nxt >= DEPTH_A)
        begin
            return '0;
        end
        return nxt[AW-1:0];
    endfunction

    // Control state
    logic [AW-1:0] write_pos_reg, write_pos_next;
    logic [AW-1:0] loop_end_reg;
    logic [AW-1:0] play_pos_reg;
    logic [AW-1:0] echo_pos_reg;
    logic [FW-1:0] fill_reg;
    logic [15:0]   mix_gain_reg;
    logic          s1_valid_reg, s2_valid_reg, out_valid_reg;

    // Pipeline payload
    logic          s1_play_ok_reg, s1_echo_ok_reg;
    product_t      s2_dry_reg, s2_wet_reg;
    logic [15:0]   dac_value_reg, dac_value_next;

    logic [15:0]   rdata_play, rdata_echo;
    logic          s1_en, s2_en, s3_en;
    logic          accept, rec_accept, play_accept;
    logic [16:0]   gain_eff, dry_gain;
    sample_t       play_smp, echo_smp;
    mix_acc_t      acc;
    logic [19:0]   q;
    logic [AW:0]   wp_inc;

    assign s3_en       = !out_valid_reg || !out_stall;
    assign s2_en       = !s2_valid_reg || s3_en;
    assign s1_en       = !s1_valid_reg || s2_en;
    assign in_stall    = !s1_en;
    assign accept      = in_valid && !in_stall;
    assign rec_accept  = accept && record_held;
    assign play_accept = accept && !record_held;

    assign wp_inc         = {1'b0, write_pos_reg} + (AW+1)'(1);
    assign write_pos_next = (wp_inc >= DEPTH_A) ? '0 : wp_inc[AW-1:0];

    alem_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (rec_accept),
        .waddr   (write_pos_reg),
        .wdata   (adc_sample - MID_CODE),
        .re      (play_accept),
        .raddr_a (play_pos_reg),
        .raddr_b (echo_pos_reg),
        .rdata_a (rdata_play),
        .rdata_b (rdata_echo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg <= '0;
            loop_end_reg  <= '0;
            play_pos_reg  <= '0;
            echo_pos_reg  <= ECHO_RESET;
            fill_reg      <= '0;
            mix_gain_reg  <= GAIN_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mix_gain_we)
            begin
                mix_gain_reg <= mix_gain_wdata;
            end
            if (rec_accept)
            begin
                write_pos_reg <= write_pos_next;
                loop_end_reg  <= write_pos_next;
                // Writes run in address order, so everything below the
                // fill count has been written at least once.
                if (fill_reg != DEPTH_F)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            if (play_accept)
            begin
                play_pos_reg <= advance(play_pos_reg, loop_end_reg);
                echo_pos_reg <= advance(echo_pos_reg, loop_end_reg);
            end
            if (s1_en)
            begin
                s1_valid_reg <= play_accept;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: validity of the two entries read this cycle.
    always_ff @(posedge clk)
    begin
        if (play_accept)
        begin
            s1_play_ok_reg <= FW'(play_pos_reg) < fill_reg;
            s1_echo_ok_reg <= FW'(echo_pos_reg) < fill_reg;
        end
    end

    // Stage 2: weight both taps.
    always_comb
    begin
        gain_eff = ({1'b0, mix_gain_reg} > UNITY_GAIN) ? UNITY_GAIN : {1'b0, mix_gain_reg};
        dry_gain = UNITY_GAIN - gain_eff;
        play_smp = s1_play_ok_reg ? sample_t'(rdata_play) : '0;
        echo_smp = s1_echo_ok_reg ? sample_t'(rdata_echo) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_dry_reg <= $signed({1'b0, dry_gain}) * play_smp;
            s2_wet_reg <= $signed({1'b0, gain_eff}) * echo_smp;
        end
    end

    // Stage 3: sum, round, restore the offset and saturate.
    always_comb
    begin
        acc = mix_acc_t'(s2_dry_reg) + mix_acc_t'(s2_wet_reg) + MIX_OFFSET;
        q   = acc[34:15];
        if (acc[34])
        begin
            dac_value_next = '0;
        end
        else if (q[19:16] != 4'd0)
        begin
            dac_value_next = 16'hFFFF;
        end
        else
        begin
            dac_value_next = q[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_valid_reg)
        begin
            dac_value_reg <= dac_value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign dac_value = dac_value_reg;

    `ALEM_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= DEPTH_F)
    `ALEM_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall,
                      s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall)
    `ALEM_ASSERT_NEXT(a_play_loads, clk, rst_n, play_accept, s1_valid_reg)
    `ALEM_ASSERT_NEXT(a_rec_fills, clk, rst_n, rec_accept, fill_reg != '0)

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Audio looper echo mix unit testbench
// Drives record and playback sample ticks through the valid/stall input
// channel, and runs a local looper model in parallel to predict each mixed
// DAC word. Every word leaving the output channel is compared with the oldest
// predicted word. The run covers a short directed table, then random phases
// with several gain settings, random idling on both channels and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alem_pkg::*;

    localparam int          LOOP_DEPTH   = 524288;
    localparam int          ECHO_OFFSET  = 4000;
    localparam int          PIPE_DEPTH   = 3;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          PHASE_TICKS  = 275;
    localparam int          NUM_PHASES   = 6;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic        REC          = 1'b1;
    localparam logic        PLAY         = 1'b0;
    localparam logic [15:0] GAIN_MAX     = 16'hFFFF;

    typedef enum logic { ROW_TICK, ROW_GAIN } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        rec;
        logic [15:0] value;     // ADC sample for a tick, gain for a gain row
        logic        fixed;     // expected word typed in below
        logic [15:0] fixed_dac;
    } stim_row_t;

    localparam int NUM_ROWS = 27;
    localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{ROW_TICK, REC,  16'hFFFF,   1'b0, 16'h0000},
        '{ROW_TICK, REC,  16'hFFFE,   1'b0, 16'h0000},
        // Reset gain, echo tap still at its start position and unwritten.
        '{ROW_TICK, PLAY, 16'h0000,   1'b1, 16'h3332},
        '{ROW_GAIN, PLAY, 16'h0000,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'hFFFF,   1'b1, 16'hFFFE},
        '{ROW_TICK, PLAY, 16'h1234,   1'b1, 16'h0000},
        '{ROW_TICK, PLAY, 16'h8000,   1'b1, 16'hFFFE},
        '{ROW_GAIN, PLAY, 16'h8000,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'h0000,   1'b1, 16'hFFFE},
        '{ROW_TICK, PLAY, 16'h7FFF,   1'b1, 16'h0000},
        '{ROW_GAIN, PLAY, GAIN_MAX,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'hABCD,   1'b1, 16'hFFFE},
        '{ROW_TICK, REC,  16'h0000,   1'b0, 16'h0000},
        '{ROW_TICK, REC,  16'h7FFF,   1'b0, 16'h0000},
        '{ROW_TICK, REC,  16'h8000,   1'b0, 16'h0000},
        '{ROW_TICK, REC,  16'h5A5A,   1'b0, 16'h0000},
        '{ROW_GAIN, PLAY, GAIN_RESET, 1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'h0001,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'hFFFF,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'h5555,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'hAAAA,   1'b0, 16'h0000},
        '{ROW_GAIN, PLAY, 16'h4000,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'h0000,   1'b0, 16'h0000},
        '{ROW_TICK, REC,  16'h2222,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'h0000,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'h0000,   1'b0, 16'h0000},
        '{ROW_TICK, PLAY, 16'h0000,   1'b0, 16'h0000}
    };

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic        record_held    = 1'b0;
    logic [15:0] adc_sample     = '0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [15:0] dac_value;
    logic        mix_gain_we    = 1'b0;
    logic [15:0] mix_gain_wdata = '0;

    // Local copy of the looper state.
    sample_t     loop_mem [int unsigned];
    int unsigned wr_pos     = 0;
    int unsigned loop_len   = 0;
    int unsigned play_pos   = 0;
    int unsigned echo_pos   = ECHO_OFFSET % LOOP_DEPTH;
    logic [15:0] gain_reg   = GAIN_RESET;

    logic [15:0] dac_expected [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          rec_ticks      = 0;
    int          play_ticks     = 0;
    int          gain_writes    = 0;
    int          src_idle_pct   = 0;
    int          snk_idle_pct   = 0;
    logic        hold_req       = 1'b0;
    logic        hold_used      = 1'b0;
    int          hold_left      = 0;

    audio_looper_echo_mix_unit #(
        .DEPTH      (LOOP_DEPTH),
        .ECHO_START (ECHO_OFFSET)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .record_held    (record_held),
        .adc_sample     (adc_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dac_value      (dac_value),
        .mix_gain_we    (mix_gain_we),
        .mix_gain_wdata (mix_gain_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic sample_t read_loop(input int unsigned pos);
        int unsigned idx;
        idx = pos % LOOP_DEPTH;
        return loop_mem.exists(idx) ? loop_mem[idx] : sample_t'(0);
    endfunction

    function automatic int unsigned next_pos(input int unsigned pos);
        int unsigned nxt;
        nxt = pos + 1;
        return (nxt >= loop_len || nxt >= LOOP_DEPTH) ? 0 : nxt;
    endfunction

    // Q0.15 weighted mix of the dry and echo taps, rounded half up and
    // clipped to the offset-binary range.
    function automatic logic [15:0] mix_sample(input sample_t dry, input sample_t wet,
                                               input logic [15:0] gain);
        longint g;
        longint acc;
        longint q;
        g   = (gain > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(gain);
        acc = (longint'(UNITY_GAIN) - g) * longint'(dry) + g * longint'(wet)
            + longint'(MID_CODE) * longint'(UNITY_GAIN) + 16384;
        q   = acc >>> 15;
        if (q < 0)
            q = 0;
        if (q > 65535)
            q = 65535;
        return q[15:0];
    endfunction

    task automatic predict_tick(input logic rec, input logic [15:0] adc,
                                output logic plays, output logic [15:0] dac);
        logic [15:0] raw;
        plays = 1'b0;
        dac   = '0;
        if (rec)
        begin
            raw = adc - MID_CODE;
            loop_mem[wr_pos % LOOP_DEPTH] = sample_t'(raw);
            wr_pos   = (wr_pos % LOOP_DEPTH) + 1;
            if (wr_pos >= LOOP_DEPTH)
                wr_pos = 0;
            loop_len = wr_pos;
        end
        else
        begin
            plays    = 1'b1;
            dac      = mix_sample(read_loop(play_pos), read_loop(echo_pos), gain_reg);
            play_pos = next_pos(play_pos);
            echo_pos = next_pos(echo_pos);
        end
    endtask

    task automatic log_mismatch(input string what, input logic [15:0] exp_dac,
                                input logic [15:0] got_dac);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch (%s): expected dac_value %h, got %h",
                     $realtime, what, exp_dac, got_dac);
    endtask

    // Presents one word and returns at the edge where it is taken.
    task automatic drive_tick(input logic rec, input logic [15:0] adc,
                              input logic fixed, input logic [15:0] fixed_dac);
        logic        plays;
        logic [15:0] dac;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        record_held <= rec;
        adc_sample  <= adc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_tick(rec, adc, plays, dac);
        if (plays)
        begin
            dac_expected.push_back(fixed ? fixed_dac : dac);
            play_ticks++;
        end
        else
            rec_ticks++;
    endtask

    // Record ticks return nothing, so the pipe is given time to empty
    // after the last expected word before the register changes.
    task automatic load_gain(input logic [15:0] g);
        in_valid <= 1'b0;
        while (dac_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 1) @(posedge clk);
        mix_gain_we    <= 1'b1;
        mix_gain_wdata <= g;
        @(posedge clk);
        mix_gain_we <= 1'b0;
        gain_reg = g;
        gain_writes++;
    endtask

    function automatic logic [15:0] pick_adc();
        if ($urandom_range(9) == 0)
            case ($urandom_range(3))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return MID_CODE;
                default: return 16'h8000;
            endcase
        return 16'($urandom());
    endfunction

    // Mostly record bursts and playback bursts, with some single random ticks.
    task automatic run_random_phase(input int n_ticks);
        int issued;
        int burst;
        int pick;
        logic rec;
        issued = 0;
        while (issued < n_ticks)
        begin
            pick = $urandom_range(99);
            if (pick < 90)
            begin
                rec   = (pick < 45) ? REC : PLAY;
                burst = rec ? $urandom_range(1, 24) : $urandom_range(1, 32);
                repeat (burst)
                begin
                    drive_tick(rec, pick_adc(), 1'b0, '0);
                    issued++;
                end
            end
            else
            begin
                drive_tick(1'($urandom_range(1)), pick_adc(), 1'b0, '0);
                issued++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (snk_idle_pct != 0) && ($urandom_range(99) < snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (dac_expected.size() == 0)
                log_mismatch("word with none expected", '0, dac_value);
            else if (dac_value !== dac_expected[0])
                log_mismatch("dac_value", dac_expected.pop_front(), dac_value);
            else
                void'(dac_expected.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, dac_expected.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] phase_gain;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 34;
        snk_idle_pct = 53;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_GAIN)
                load_gain(DIRECTED_ROWS[i].value);
            else
                drive_tick(DIRECTED_ROWS[i].rec, DIRECTED_ROWS[i].value,
                           DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].fixed_dac);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       phase_gain = GAIN_RESET;
                1:       phase_gain = 16'h0000;
                2:       phase_gain = UNITY_GAIN[15:0];
                3:       phase_gain = GAIN_MAX;
                4:       phase_gain = 16'($urandom_range(0, 32768));
                default: phase_gain = 16'($urandom());
            endcase
            load_gain(phase_gain);
            src_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 53 : 0;
            snk_idle_pct = (ph < 2) ? 53 : (ph < 4) ? 34 : 0;
            // One long receiver hold-off while words keep coming, so the
            // pipe fills and the input channel has to stall.
            if (ph == 4)
                hold_req <= 1'b1;
            run_random_phase(PHASE_TICKS);
        end

        in_valid <= 1'b0;
        while (dac_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 5) @(posedge clk);

        $display("Ran %0d record ticks and %0d playback words through %0d gain writes,",
                 rec_ticks, play_ticks, gain_writes);
        $display("with idling on both channels and a %0d-cycle output hold-off; %0d mismatches.",
                 HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
